### hw/rtl/gpt_pkg.sv
package gpt_pkg;

    localparam int unsigned SET_WIDTH = 256;

    // Token kinds.
    localparam logic [2:0] KIND_LIT = 3'd0;
    localparam logic [2:0] KIND_ONE = 3'd1;
    localparam logic [2:0] KIND_RUN = 3'd2;
    localparam logic [2:0] KIND_REC = 3'd3;
    localparam logic [2:0] KIND_SET = 3'd4;

    // Set modifiers.
    localparam logic [1:0] MOD_NONE = 2'd0;
    localparam logic [1:0] MOD_OPT  = 2'd1;
    localparam logic [1:0] MOD_PLUS = 2'd2;
    localparam logic [1:0] MOD_STAR = 2'd3;

    // Pattern characters.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           lit;
        logic [1:0]           modifier;
        logic [SET_WIDTH-1:0] bits;
        logic                 terminal;
        logic                 error;
    } tok_t;

    // Results of one item: up to two tokens, first in r0.
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       r0;
        tok_t       r1;
    } res_t;

endpackage

### hw/rtl/gpt_parser.sv
module gpt_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            fire,
    input  logic            cmd,
    input  logic [7:0]      pbyte,
    input  logic            ci,
    output gpt_pkg::res_t   res
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_STAR,
        MODE_AFTER_DSTAR,
        MODE_SET,
        MODE_SET_DONE
    } mode_t;

    localparam logic [7:0] CH_A_UPPER  = 8'h41;
    localparam logic [7:0] CH_Z_UPPER  = 8'h5A;
    localparam logic [7:0] CH_A_LOWER  = 8'h61;
    localparam logic [7:0] CH_Z_LOWER  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] CODE_MAX    = 8'd255;

    localparam logic [gpt_pkg::SET_WIDTH-1:0] SET_ONE =
        {{(gpt_pkg::SET_WIDTH-1){1'b0}}, 1'b1};

    function automatic logic [7:0] lower8(input logic [7:0] c);
        lower8 = (c >= CH_A_UPPER && c <= CH_Z_UPPER) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic [7:0] upper8(input logic [7:0] c);
        upper8 = (c >= CH_A_LOWER && c <= CH_Z_LOWER) ? c - CASE_OFFSET : c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= CH_A_UPPER && c <= CH_Z_UPPER) ||
                    (c >= CH_A_LOWER && c <= CH_Z_LOWER);
    endfunction

    function automatic logic [gpt_pkg::SET_WIDTH-1:0] range_mask(
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        logic [gpt_pkg::SET_WIDTH-1:0] ones;
        ones = '1;
        range_mask = (ones << lo) & (ones >> (CODE_MAX - hi));
    endfunction

    function automatic logic [gpt_pkg::SET_WIDTH-1:0] single_mask(
        input logic [7:0] c,
        input logic       fold
    );
        logic [gpt_pkg::SET_WIDTH-1:0] m;
        m = SET_ONE << (fold ? lower8(c) : c);
        if (fold && is_letter(c)) begin
            m = m | (SET_ONE << upper8(c));
        end
        single_mask = m;
    endfunction

    function automatic gpt_pkg::tok_t make_tok(
        input logic [2:0]                    kind,
        input logic [7:0]                    lit,
        input logic [1:0]                    modifier,
        input logic [gpt_pkg::SET_WIDTH-1:0] bits
    );
        gpt_pkg::tok_t t;
        t.kind     = kind;
        t.lit      = lit;
        t.modifier = modifier;
        t.bits     = bits;
        t.terminal = 1'b0;
        t.error    = 1'b0;
        make_tok = t;
    endfunction

    mode_t                          mode_reg, mode_next;
    logic [7:0]                     pend_reg, pend_next;
    logic [1:0]                     pcount_reg, pcount_next;
    logic [gpt_pkg::SET_WIDTH-1:0]  bitmap_reg, bitmap_next;
    gpt_pkg::tok_t                  held_reg, held_next;
    logic                           held_valid_reg, held_valid_next;
    logic                           error_seen_reg, error_seen_next;

    // Outcome of a byte seen in normal context.
    logic                           nb_push;
    gpt_pkg::tok_t                  nb_tok;
    mode_t                          nb_mode;
    logic                           nb_open;

    // Set range terms.
    logic [7:0]                     rng_start, rng_end;
    logic                           rng_reversed;
    logic [gpt_pkg::SET_WIDTH-1:0]  rng_bits;
    logic [gpt_pkg::SET_WIDTH-1:0]  pend_single, dash_single;

    logic                           pre_push;
    gpt_pkg::tok_t                  pre_tok;
    logic                           do_nb, nb_fired, do_bracket;
    logic                           raise, clear_all;

    always_comb begin
        nb_push = 1'b0;
        nb_open = 1'b0;
        nb_mode = MODE_NORMAL;
        nb_tok  = make_tok(gpt_pkg::KIND_LIT, ci ? lower8(pbyte) : pbyte,
                           gpt_pkg::MOD_NONE, '0);
        case (pbyte)
            gpt_pkg::CH_STAR: begin
                nb_mode = MODE_STAR;
            end
            gpt_pkg::CH_QUEST: begin
                nb_push = 1'b1;
                nb_tok  = make_tok(gpt_pkg::KIND_ONE, 8'd0, gpt_pkg::MOD_NONE, '0);
            end
            gpt_pkg::CH_OPEN: begin
                nb_mode = MODE_SET;
                nb_open = 1'b1;
            end
            default: begin
                nb_push = 1'b1;
            end
        endcase
    end

    always_comb begin
        rng_start    = ci ? lower8(pend_reg) : pend_reg;
        rng_end      = ci ? lower8(pbyte) : pbyte;
        rng_reversed = rng_start > rng_end;
        rng_bits     = range_mask(rng_start, rng_end);
        if (ci && is_letter(rng_start)) begin
            rng_bits = rng_bits | range_mask(upper8(rng_start), upper8(rng_end));
        end
        pend_single = single_mask(pend_reg, ci);
        dash_single = single_mask(gpt_pkg::CH_DASH, ci);
    end

    // The results and next state are worked out for the waiting item as if it
    // were taken; the registers only move when it actually is.
    always_comb begin
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        pcount_next     = pcount_reg;
        bitmap_next     = bitmap_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        error_seen_next = error_seen_reg;
        pre_push        = 1'b0;
        pre_tok         = make_tok(gpt_pkg::KIND_RUN, 8'd0, gpt_pkg::MOD_NONE, '0);
        do_nb           = 1'b0;
        do_bracket      = 1'b0;
        raise           = 1'b0;
        clear_all       = 1'b0;
        res             = '0;

        if (in_valid && !error_seen_reg) begin
            if (cmd) begin
                unique case (mode_reg)
                    MODE_STAR: begin
                        pre_push = 1'b1;
                    end
                    MODE_SET_DONE: begin
                        pre_push = 1'b1;
                        pre_tok  = make_tok(gpt_pkg::KIND_SET, 8'd0,
                                            gpt_pkg::MOD_NONE, bitmap_reg);
                    end
                    MODE_SET: begin
                        raise = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else begin
                unique case (mode_reg)
                    MODE_STAR: begin
                        if (pbyte == gpt_pkg::CH_STAR) begin
                            pre_push  = 1'b1;
                            pre_tok   = make_tok(gpt_pkg::KIND_REC, 8'd0,
                                                 gpt_pkg::MOD_NONE, '0);
                            mode_next = MODE_AFTER_DSTAR;
                        end else begin
                            pre_push = 1'b1;
                            do_nb    = 1'b1;
                        end
                    end
                    MODE_AFTER_DSTAR: begin
                        mode_next = MODE_NORMAL;
                        do_nb     = pbyte != gpt_pkg::CH_SLASH;
                    end
                    MODE_SET: begin
                        case (pcount_reg)
                            2'd1: begin
                                if (pbyte == gpt_pkg::CH_DASH) begin
                                    pcount_next = 2'd2;
                                end else begin
                                    bitmap_next = bitmap_reg | pend_single;
                                    pcount_next = 2'd0;
                                    do_bracket  = 1'b1;
                                end
                            end
                            2'd2: begin
                                pcount_next = 2'd0;
                                if (pbyte != gpt_pkg::CH_CLOSE) begin
                                    if (rng_reversed) begin
                                        raise = 1'b1;
                                    end else begin
                                        bitmap_next = bitmap_reg | rng_bits;
                                    end
                                end else begin
                                    bitmap_next = bitmap_reg | pend_single | dash_single;
                                    do_bracket  = 1'b1;
                                end
                            end
                            default: begin
                                do_bracket = 1'b1;
                            end
                        endcase
                    end
                    MODE_SET_DONE: begin
                        mode_next = MODE_NORMAL;
                        pre_push  = 1'b1;
                        pre_tok   = make_tok(gpt_pkg::KIND_SET, 8'd0,
                                             gpt_pkg::MOD_NONE, bitmap_reg);
                        case (pbyte)
                            gpt_pkg::CH_QUEST: pre_tok.modifier = gpt_pkg::MOD_OPT;
                            gpt_pkg::CH_PLUS:  pre_tok.modifier = gpt_pkg::MOD_PLUS;
                            gpt_pkg::CH_STAR:  pre_tok.modifier = gpt_pkg::MOD_STAR;
                            default:           do_nb = 1'b1;
                        endcase
                    end
                    default: begin
                        do_nb = 1'b1;
                    end
                endcase
            end
        end

        if (do_bracket) begin
            if (pbyte == gpt_pkg::CH_CLOSE) begin
                mode_next = MODE_SET_DONE;
            end else begin
                pend_next   = pbyte;
                pcount_next = 2'd1;
            end
        end

        nb_fired = do_nb && nb_push;

        if (do_nb) begin
            mode_next = nb_mode;
            if (nb_open) begin
                pcount_next = 2'd0;
                bitmap_next = '0;
            end
        end

        // A new token takes the held place and pushes the held one out.
        if (in_valid && !cmd && (pre_push || nb_fired)) begin
            held_next       = nb_fired ? nb_tok : pre_tok;
            held_valid_next = 1'b1;
            res.cnt         = {1'b0, held_valid_reg} + {1'b0, pre_push && nb_fired};
            res.r0          = held_valid_reg ? held_reg : pre_tok;
            res.r1          = pre_tok;
        end

        // End of pattern flushes everything, the last token marked terminal.
        if (in_valid && cmd) begin
            clear_all = 1'b1;
            if (!error_seen_reg) begin
                res.cnt = {1'b0, held_valid_reg} + {1'b0, pre_push};
                res.r0  = held_valid_reg ? held_reg : pre_tok;
                res.r1  = pre_tok;
                if (res.cnt == 2'd2) begin
                    res.r1.terminal = 1'b1;
                end else begin
                    res.r0.terminal = 1'b1;
                end
            end
        end

        if (clear_all || raise) begin
            mode_next       = MODE_NORMAL;
            pend_next       = 8'd0;
            pcount_next     = 2'd0;
            bitmap_next     = '0;
            held_next       = '0;
            held_valid_next = 1'b0;
            error_seen_next = 1'b0;
        end

        // An error result replaces anything else this item would give.
        if (raise) begin
            error_seen_next = 1'b1;
            res             = '0;
            res.cnt         = 2'd1;
            res.r0.error    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            pend_reg       <= 8'd0;
            pcount_reg     <= 2'd0;
            bitmap_reg     <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            error_seen_reg <= 1'b0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            pcount_reg     <= pcount_next;
            bitmap_reg     <= bitmap_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            error_seen_reg <= error_seen_next;
        end
    end

`ifndef SYNTHESIS
    // A half-read set element only exists inside a bracket set.
    a_pcount_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (pcount_reg != 2'd0) |-> (mode_reg == MODE_SET))
        else $error("pending set characters outside a set");

    // After an error nothing is kept but the error mark itself.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        error_seen_reg |-> (!held_valid_reg && mode_reg == MODE_NORMAL))
        else $error("pattern state kept after an error");

    // A byte item never gives a terminal token.
    a_terminal_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !cmd && res.cnt != 2'd0) |-> (!res.r0.terminal && !res.r1.terminal))
        else $error("terminal token from a pattern byte");
`endif

endmodule

### hw/rtl/gpt_out.sv
module gpt_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  gpt_pkg::res_t   res,
    output logic            can_load,
    output logic            m_valid,
    input  logic            m_ready,
    output gpt_pkg::tok_t   m_tok,
    output logic            m_run_last
);

    gpt_pkg::tok_t  slot0_reg, slot1_reg;
    logic [1:0]     cnt_reg;
    logic           take;

    assign take       = m_valid && m_ready;
    assign m_valid    = cnt_reg != 2'd0;
    assign m_tok      = slot0_reg;
    assign m_run_last = cnt_reg == 2'd1;
    // A new pair may enter when nothing waits, or when the last waiting item leaves in this cycle.
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= res.r0;
            slot1_reg <= res.r1;
        end else if (take) begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef SYNTHESIS
    // The first of two results is always followed by the second.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_last) |=> m_valid)
        else $error("second result of an item lost");

    // An error result stands alone and carries no token.
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tok.error) |->
            (m_run_last && !m_tok.terminal && m_tok.kind == gpt_pkg::KIND_LIT))
        else $error("malformed error result");

    // Results are never overwritten before they are taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("result buffer overwritten");
`endif

endmodule

### hw/rtl/glob_pattern_tokenizer.sv
// Glob pattern tokenizer.
// Input channel (s_valid/s_ready): one item per pattern byte with s_cmd low,
// and one item with s_cmd high at the end of each pattern.
// Result channel (m_valid/m_ready): one token per transfer on the m_ ports.
// An item gives zero, one or two tokens; m_run_last marks the last token of
// an item. The final token of a pattern has m_terminal set, and a malformed
// pattern gives a single token with m_error_code set, after which bytes are
// ignored up to the end of the pattern.
// cfg_wr_en/cfg_wr_data write the case folding flag; write it only while idle.
// An accepted item is held in the input register, and its tokens are then loaded
// into the output pair register that drives the m_ ports.
// Throughput: one item per cycle while each gives at most one token and m_ready
// is high; an item with two tokens holds the output pair register until both
// have left, as the result channel moves one token per cycle.
// When m_ready is low the pair register and the input register fill up and
// s_ready falls; nothing is dropped.
// A synchronous active-low reset clears the parse state and the case flag;
// no clearing pass is needed afterwards.
module glob_pattern_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_pattern_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [7:0]  m_literal_byte,
    output logic [1:0]  m_set_modifier,
    output logic [63:0] m_set_bits_low,
    output logic [63:0] m_set_bits_mid_low,
    output logic [63:0] m_set_bits_mid_high,
    output logic [63:0] m_set_bits_high,
    output logic        m_terminal,
    output logic        m_error_code,
    output logic        m_run_last
);

    logic           ci_reg;
    logic           in_valid_reg;
    logic           in_cmd_reg;
    logic [7:0]     in_byte_reg;
    logic           fire;
    logic           can_load;
    gpt_pkg::res_t  res;
    gpt_pkg::tok_t  out_tok;

    assign fire    = in_valid_reg && (res.cnt == 2'd0 || can_load);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ci_reg       <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ci_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_pattern_byte;
        end
    end

    gpt_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .fire     (fire),
        .cmd      (in_cmd_reg),
        .pbyte    (in_byte_reg),
        .ci       (ci_reg),
        .res      (res)
    );

    gpt_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire && res.cnt != 2'd0),
        .res        (res),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tok      (out_tok),
        .m_run_last (m_run_last)
    );

    assign m_token_kind        = out_tok.kind;
    assign m_literal_byte      = out_tok.lit;
    assign m_set_modifier      = out_tok.modifier;
    assign m_set_bits_low      = out_tok.bits[63:0];
    assign m_set_bits_mid_low  = out_tok.bits[127:64];
    assign m_set_bits_mid_high = out_tok.bits[191:128];
    assign m_set_bits_high     = out_tok.bits[255:192];
    assign m_terminal          = out_tok.terminal;
    assign m_error_code        = out_tok.error;

endmodule

### bench/glob_pattern_tokenizer_checker.sv
`timescale 1ns / 100ps

module glob_pattern_tokenizer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_pattern_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_token_kind,
    input  logic [7:0]  m_literal_byte,
    input  logic [1:0]  m_set_modifier,
    input  logic [63:0] m_set_bits_low,
    input  logic [63:0] m_set_bits_mid_low,
    input  logic [63:0] m_set_bits_mid_high,
    input  logic [63:0] m_set_bits_high,
    input  logic        m_terminal,
    input  logic        m_error_code,
    input  logic        m_run_last,
    output int          fail_count,
    output int          outstanding,
    output int          tokens_checked,
    output int          error_tokens
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_STAR,
        MODE_AFTER_DSTAR,
        MODE_SET,
        MODE_SET_DONE
    } parse_mode_t;

    typedef struct packed {
        logic [2:0]                    kind;
        logic [7:0]                    lit;
        logic [1:0]                    modifier;
        logic [gpt_pkg::SET_WIDTH-1:0] bits;
        logic                          terminal;
        logic                          is_error;
        logic                          run_last;
    } token_t;

    logic                          case_fold;
    parse_mode_t                   mode;
    logic [7:0]                    pend_ch [2];
    logic [1:0]                    pend_cnt;
    logic [gpt_pkg::SET_WIDTH-1:0] set_map;
    token_t                        held_tok;
    logic                          held_valid;
    logic                          err_seen;

    token_t step_tokens[$];
    token_t expected_tokens[$];

    initial begin
        fail_count = 0;
        outstanding = 0;
        tokens_checked = 0;
        error_tokens = 0;
    end

    function automatic logic [7:0] lower_ch(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] upper_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void mark_span(logic [7:0] lo, logic [7:0] hi);
        int v;
        for (v = lo; v <= hi; v++) set_map[v] = 1'b1;
    endfunction

    function automatic void add_member(logic [7:0] c);
        if (case_fold) begin
            set_map[lower_ch(c)] = 1'b1;
            if (is_alpha(c)) set_map[upper_ch(c)] = 1'b1;
        end else begin
            set_map[c] = 1'b1;
        end
    endfunction

    // Returns 0 when the range runs backwards once folded.
    function automatic logic add_span(logic [7:0] s, logic [7:0] e);
        if (case_fold) begin
            s = lower_ch(s);
            e = lower_ch(e);
        end
        if (s > e) return 1'b0;
        mark_span(s, e);
        if (case_fold && is_alpha(s)) mark_span(upper_ch(s), upper_ch(e));
        return 1'b1;
    endfunction

    function automatic void emit(token_t t, logic term);
        t.terminal = term;
        t.is_error = 1'b0;
        t.run_last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    // A finished token is only released once the next one exists.
    function automatic void push_tok(logic [2:0] kind, logic [7:0] lit, logic [1:0] modifier,
                                     logic [gpt_pkg::SET_WIDTH-1:0] bits);
        if (held_valid) emit(held_tok, 1'b0);
        held_tok = '0;
        held_tok.kind = kind;
        held_tok.lit = lit;
        held_tok.modifier = modifier;
        held_tok.bits = bits;
        held_valid = 1'b1;
    endfunction

    function automatic void clear_pattern();
        mode = MODE_NORMAL;
        pend_ch[0] = '0;
        pend_ch[1] = '0;
        pend_cnt = '0;
        set_map = '0;
        held_tok = '0;
        held_valid = 1'b0;
        err_seen = 1'b0;
    endfunction

    function automatic void raise_error();
        token_t t;
        step_tokens.delete();
        clear_pattern();
        t = '0;
        t.is_error = 1'b1;
        step_tokens.push_back(t);
        err_seen = 1'b1;
    endfunction

    function automatic void normal_byte(logic [7:0] b);
        if (b == gpt_pkg::CH_STAR) begin
            mode = MODE_STAR;
        end else if (b == gpt_pkg::CH_QUEST) begin
            push_tok(gpt_pkg::KIND_ONE, 8'd0, gpt_pkg::MOD_NONE, '0);
        end else if (b == gpt_pkg::CH_OPEN) begin
            mode = MODE_SET;
            pend_cnt = '0;
            set_map = '0;
        end else begin
            push_tok(gpt_pkg::KIND_LIT, case_fold ? lower_ch(b) : b, gpt_pkg::MOD_NONE, '0);
        end
    endfunction

    function automatic logic set_byte(logic [7:0] b);
        if (pend_cnt == 2'd1) begin
            if (b == gpt_pkg::CH_DASH) begin
                pend_ch[1] = b;
                pend_cnt = 2'd2;
                return 1'b1;
            end
            add_member(pend_ch[0]);
            pend_cnt = '0;
        end else if (pend_cnt >= 2'd2) begin
            pend_cnt = '0;
            if (b != gpt_pkg::CH_CLOSE) return add_span(pend_ch[0], b);
            // A dash right before the closing bracket is a member.
            add_member(pend_ch[0]);
            add_member(gpt_pkg::CH_DASH);
        end
        if (b == gpt_pkg::CH_CLOSE) begin
            mode = MODE_SET_DONE;
        end else begin
            pend_ch[0] = b;
            pend_cnt = 2'd1;
        end
        return 1'b1;
    endfunction

    function automatic void predict_tokens(logic cmd, logic [7:0] b);
        step_tokens.delete();
        if (cmd) begin
            if (!err_seen) begin
                case (mode)
                    MODE_STAR:
                        push_tok(gpt_pkg::KIND_RUN, 8'd0, gpt_pkg::MOD_NONE, '0);
                    MODE_SET_DONE:
                        push_tok(gpt_pkg::KIND_SET, 8'd0, gpt_pkg::MOD_NONE, set_map);
                    MODE_SET:
                        raise_error();
                    default: ;
                endcase
                if (!err_seen && held_valid) emit(held_tok, 1'b1);
                // An unclosed set leaves the error flag standing for the next pattern.
                if (!err_seen || step_tokens.size() == 0) clear_pattern();
            end
            if (step_tokens.size() == 0) clear_pattern();
        end else if (!err_seen) begin
            case (mode)
                MODE_STAR: begin
                    if (b == gpt_pkg::CH_STAR) begin
                        push_tok(gpt_pkg::KIND_REC, 8'd0, gpt_pkg::MOD_NONE, '0);
                        mode = MODE_AFTER_DSTAR;
                    end else begin
                        push_tok(gpt_pkg::KIND_RUN, 8'd0, gpt_pkg::MOD_NONE, '0);
                        mode = MODE_NORMAL;
                        normal_byte(b);
                    end
                end
                MODE_AFTER_DSTAR: begin
                    mode = MODE_NORMAL;
                    if (b != gpt_pkg::CH_SLASH) normal_byte(b);
                end
                MODE_SET: begin
                    if (!set_byte(b)) raise_error();
                end
                MODE_SET_DONE: begin
                    mode = MODE_NORMAL;
                    if (b == gpt_pkg::CH_QUEST) begin
                        push_tok(gpt_pkg::KIND_SET, 8'd0, gpt_pkg::MOD_OPT, set_map);
                    end else if (b == gpt_pkg::CH_PLUS) begin
                        push_tok(gpt_pkg::KIND_SET, 8'd0, gpt_pkg::MOD_PLUS, set_map);
                    end else if (b == gpt_pkg::CH_STAR) begin
                        push_tok(gpt_pkg::KIND_SET, 8'd0, gpt_pkg::MOD_STAR, set_map);
                    end else begin
                        push_tok(gpt_pkg::KIND_SET, 8'd0, gpt_pkg::MOD_NONE, set_map);
                        normal_byte(b);
                    end
                end
                default: begin
                    mode = MODE_NORMAL;
                    normal_byte(b);
                end
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("token %0d %s got %h, expected %h",
                                      tokens_checked, name, got, want));
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("token of kind %0d arrived with nothing expected",
                                      m_token_kind));
            return;
        end
        want = expected_tokens.pop_front();
        check_field("token_kind", m_token_kind, want.kind);
        check_field("literal_byte", m_literal_byte, want.lit);
        check_field("set_modifier", m_set_modifier, want.modifier);
        check_field("set_bits_low", m_set_bits_low, want.bits[63:0]);
        check_field("set_bits_mid_low", m_set_bits_mid_low, want.bits[127:64]);
        check_field("set_bits_mid_high", m_set_bits_mid_high, want.bits[191:128]);
        check_field("set_bits_high", m_set_bits_high, want.bits[255:192]);
        check_field("terminal", m_terminal, want.terminal);
        check_field("error_code", m_error_code, want.is_error);
        check_field("run_last", m_run_last, want.run_last);
        if (want.is_error) error_tokens++;
        tokens_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            case_fold = 1'b0;
            clear_pattern();
            expected_tokens.delete();
        end else begin
            if (cfg_wr_en) case_fold = cfg_wr_data;
            if (s_valid && s_ready) predict_tokens(s_cmd, s_pattern_byte);
            if (m_valid && m_ready) check_token();
        end
        outstanding = expected_tokens.size();
    end

endmodule

### bench/glob_pattern_tokenizer_test.sv
`timescale 1ns / 100ps

module glob_pattern_tokenizer_test;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 300;
    localparam int PHASE_ITEMS    = 350;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [7:0]  s_pattern_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_token_kind;
    logic [7:0]  m_literal_byte;
    logic [1:0]  m_set_modifier;
    logic [63:0] m_set_bits_low;
    logic [63:0] m_set_bits_mid_low;
    logic [63:0] m_set_bits_mid_high;
    logic [63:0] m_set_bits_high;
    logic        m_terminal;
    logic        m_error_code;
    logic        m_run_last;

    int fail_count;
    int outstanding;
    int tokens_checked;
    int error_tokens;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int items_sent = 0;
    int patterns_sent = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    glob_pattern_tokenizer dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_pattern_byte      (s_pattern_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_token_kind        (m_token_kind),
        .m_literal_byte      (m_literal_byte),
        .m_set_modifier      (m_set_modifier),
        .m_set_bits_low      (m_set_bits_low),
        .m_set_bits_mid_low  (m_set_bits_mid_low),
        .m_set_bits_mid_high (m_set_bits_mid_high),
        .m_set_bits_high     (m_set_bits_high),
        .m_terminal          (m_terminal),
        .m_error_code        (m_error_code),
        .m_run_last          (m_run_last)
    );

    glob_pattern_tokenizer_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_pattern_byte      (s_pattern_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_token_kind        (m_token_kind),
        .m_literal_byte      (m_literal_byte),
        .m_set_modifier      (m_set_modifier),
        .m_set_bits_low      (m_set_bits_low),
        .m_set_bits_mid_low  (m_set_bits_mid_low),
        .m_set_bits_mid_high (m_set_bits_mid_high),
        .m_set_bits_high     (m_set_bits_high),
        .m_terminal          (m_terminal),
        .m_error_code        (m_error_code),
        .m_run_last          (m_run_last),
        .fail_count          (fail_count),
        .outstanding         (outstanding),
        .tokens_checked      (tokens_checked),
        .error_tokens        (error_tokens)
    );

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with s_valid still high.
    task automatic send_item(logic cmd, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_pattern_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom_range(255)));
        patterns_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    // Waits for every token to come back, then keeps waiting so that items which
    // produce nothing but may still be in flight get through.
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_case_fold(logic v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] random_set_char();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = 8'($urandom_range("a", "z"));
            1:       c = 8'($urandom_range("A", "Z"));
            2:       c = 8'($urandom_range("0", "9"));
            default: c = 8'($urandom_range(255));
        endcase
        if (c == gpt_pkg::CH_CLOSE) c = gpt_pkg::CH_DASH;
        return c;
    endfunction

    // Mostly well-formed patterns built from random elements; the rest is raw
    // noise, unclosed sets and backwards ranges.
    task automatic send_random_pattern();
        logic [7:0] pat[$];
        logic [7:0] a, b, t;
        int n_elem, sel, members;
        n_elem = $urandom_range(1, 8);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) pat.push_back(8'($urandom_range(255)));
        end else begin
            for (int k = 0; k < n_elem; k++) begin
                sel = $urandom_range(99);
                if (sel < 35) begin
                    if ($urandom_range(4) < 3) pat.push_back(random_set_char());
                    else pat.push_back(8'($urandom_range(255)));
                end else if (sel < 45) begin
                    pat.push_back(gpt_pkg::CH_QUEST);
                end else if (sel < 55) begin
                    pat.push_back(gpt_pkg::CH_STAR);
                end else if (sel < 63) begin
                    pat.push_back(gpt_pkg::CH_STAR);
                    pat.push_back(gpt_pkg::CH_STAR);
                    if ($urandom_range(1)) pat.push_back(gpt_pkg::CH_SLASH);
                end else begin
                    pat.push_back(gpt_pkg::CH_OPEN);
                    members = $urandom_range(0, 4);
                    for (int j = 0; j < members; j++) begin
                        if ($urandom_range(2) == 0) begin
                            a = random_set_char();
                            b = random_set_char();
                            if (a > b && $urandom_range(7) != 0) begin
                                t = a;
                                a = b;
                                b = t;
                            end
                            pat.push_back(a);
                            pat.push_back(gpt_pkg::CH_DASH);
                            pat.push_back(b);
                        end else begin
                            pat.push_back(random_set_char());
                        end
                    end
                    if ($urandom_range(19) != 0) pat.push_back(gpt_pkg::CH_CLOSE);
                    case ($urandom_range(5))
                        0:       pat.push_back(gpt_pkg::CH_QUEST);
                        1:       pat.push_back(gpt_pkg::CH_PLUS);
                        2:       pat.push_back(gpt_pkg::CH_STAR);
                        default: ;
                    endcase
                end
            end
        end
        foreach (pat[i]) send_item(1'b0, pat[i]);
        send_end();
    endtask

    // Output side: random back-pressure, and one long hold-off per request.
    initial begin
        int served;
        served = 0;
        forever begin
            @(negedge aclk);
            if (stall_requests != served) begin
                served++;
                m_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d tokens still expected",
                     $time, quiet_cycles, outstanding);
            $display("FAIL glob_pattern_tokenizer");
            $finish;
        end
    end

    initial begin
        int phase_start;
        logic paused;
        logic stalled;
        paused = 1'b0;
        stalled = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 31;
        recv_idle_pct = 73;
        send_text("*?");
        send_end();
        send_text("**/");
        send_end();
        send_text("[]*");
        send_end();
        send_text("[-a-]");
        send_end();
        // A backwards range, then an end of pattern that gives no token.
        send_text("[z-a");
        send_end();
        // An unclosed set keeps the error until the following end of pattern.
        send_text("[");
        send_end();
        send_end();
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_end();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_case_fold(1'b1);
                    send_idle_pct = 31;
                    recv_idle_pct = 73;
                end
                1: begin
                    write_case_fold(1'b0);
                    send_idle_pct = 73;
                    recv_idle_pct = 31;
                end
                2: begin
                    write_case_fold(1'b1);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                default: begin
                    write_case_fold(1'b0);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_pattern();
                if (phase == 1 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if (phase == 2 && !stalled && items_sent - phase_start > 100) begin
                    stall_requests++;
                    stalled = 1'b1;
                end
            end
        end

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d items in %0d patterns and checked %0d tokens, %0d of them errors.",
                 items_sent, patterns_sent, tokens_checked, error_tokens);
        $display("Case folding ran off and on under three idling mixes and one long stall.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS glob_pattern_tokenizer");
        end else begin
            $display("FAIL glob_pattern_tokenizer");
        end
        $finish;
    end

endmodule
